// ===== design/utf8_byte_stream_decoder_assert.svh =====
// Assertion macros for the UTF-8 byte stream decoder
`ifndef UTF8_BYTE_STREAM_DECODER_ASSERT_SVH
`define UTF8_BYTE_STREAM_DECODER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define UBSD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define UBSD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define UBSD_ASSERT(label, prop, msg)
`define UBSD_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== design/ubsd_pkg.sv =====
package ubsd_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned CP_W      = 21;
   localparam int unsigned PEND_W    = 2;
   localparam int unsigned PAYLOAD_W = 6;

   localparam logic [BYTE_W-1:0] ASCII_LIMIT  = 8'h80;
   localparam logic [BYTE_W-1:0] LEAD2_MIN    = 8'hC2;
   localparam logic [BYTE_W-1:0] LEAD3_MIN    = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD4_MIN    = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD_LIMIT   = 8'hF5;
   localparam logic [BYTE_W-1:0] CONT_MASK    = 8'hC0;
   localparam logic [BYTE_W-1:0] CONT_TAG     = 8'h80;
   localparam logic [BYTE_W-1:0] LEAD2_MASK   = 8'h1F;
   localparam logic [BYTE_W-1:0] LEAD3_MASK   = 8'h0F;
   localparam logic [BYTE_W-1:0] LEAD4_MASK   = 8'h07;

   localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;
   localparam logic [CP_W-1:0] SURROGATE_LO = 21'h00D800;
   localparam logic [CP_W-1:0] SURROGATE_HI = 21'h00DFFF;

   localparam logic [PEND_W-1:0] PEND_IDLE  = 2'd0;
   localparam logic [PEND_W-1:0] PEND_ONE   = 2'd1;
   localparam logic [PEND_W-1:0] PEND_TWO   = 2'd2;
   localparam logic [PEND_W-1:0] PEND_THREE = 2'd3;

   typedef enum logic [1:0] {
      STATUS_OK  = 2'd0,
      STATUS_ERR = 2'd1,
      STATUS_END = 2'd2
   } status_type;

   typedef struct packed {
      logic [PEND_W-1:0] pending;
      logic [CP_W-1:0]   partial;
   } dec_state_type;

   typedef struct packed {
      logic              emit;
      logic [CP_W-1:0]   code_point;
      status_type        status;
   } dec_result_type;

endpackage

// ===== design/ubsd_step.sv =====
module ubsd_step
   import ubsd_pkg::*;
(
   input  dec_state_type     state_cur,
   input  logic [BYTE_W-1:0] byte_in,
   input  logic              stream_end,
   output dec_state_type     state_nxt,
   output dec_result_type    result
);

   logic [CP_W-1:0] accum;

   assign accum = {state_cur.partial[CP_W-PAYLOAD_W-1:0], byte_in[PAYLOAD_W-1:0]};

   always_comb begin
      state_nxt         = state_cur;
      result.emit       = 1'b0;
      result.code_point = '0;
      result.status     = STATUS_OK;
      priority if (stream_end) begin
         result.emit   = 1'b1;
         result.status = (state_cur.pending != PEND_IDLE) ? STATUS_ERR : STATUS_END;
         state_nxt     = '0;
      end else if (state_cur.pending == PEND_IDLE) begin
         priority if (byte_in < ASCII_LIMIT) begin
            result.emit       = 1'b1;
            result.code_point = CP_W'(byte_in);
         end else if (byte_in >= LEAD2_MIN && byte_in < LEAD3_MIN) begin
            state_nxt.pending = PEND_ONE;
            state_nxt.partial = CP_W'(byte_in & LEAD2_MASK);
         end else if (byte_in >= LEAD3_MIN && byte_in < LEAD4_MIN) begin
            state_nxt.pending = PEND_TWO;
            state_nxt.partial = CP_W'(byte_in & LEAD3_MASK);
         end else if (byte_in >= LEAD4_MIN && byte_in < LEAD_LIMIT) begin
            state_nxt.pending = PEND_THREE;
            state_nxt.partial = CP_W'(byte_in & LEAD4_MASK);
         end else begin
            result.emit   = 1'b1;
            result.status = STATUS_ERR;
            state_nxt     = '0;
         end
      end else if ((byte_in & CONT_MASK) != CONT_TAG) begin
         result.emit   = 1'b1;
         result.status = STATUS_ERR;
         state_nxt     = '0;
      end else if (state_cur.pending != PEND_ONE) begin
         state_nxt.pending = state_cur.pending - PEND_ONE;
         state_nxt.partial = accum;
      end else begin
         result.emit = 1'b1;
         state_nxt   = '0;
         if ((accum >= SURROGATE_LO && accum <= SURROGATE_HI) || accum > CP_MAX) begin
            result.status = STATUS_ERR;
         end else begin
            result.code_point = accum;
         end
      end
   end

endmodule

// ===== design/utf8_byte_stream_decoder.sv =====
// A byte accepted on req passes through the input register and the result register to rsp.
// One item per cycle unless rsp stalls; lead and middle bytes of sequences give no result.
// Stalls on rsp hold both the input and result registers; req_tready falls only then.
// Reset (synchronous, active high) empties both registers and returns the decoder to idle.
`include "utf8_byte_stream_decoder_assert.svh"

module utf8_byte_stream_decoder
   import ubsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_in
   input  logic [0:0]  req_tuser,   // [0] stream_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [20:0] code_point, [23:21] zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_end_ff;
   dec_state_type     state_ff, state_in;
   logic              out_valid_ff, out_valid_in;
   logic [CP_W-1:0]   out_cp_ff;
   status_type        out_status_ff;
   dec_result_type    step_result;
   logic              advance;
   logic              req_take;

   assign advance  = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take = req_tvalid && req_tready;

   ubsd_step u_step (
      .state_cur  (state_ff),
      .byte_in    (in_byte_ff),
      .stream_end (in_end_ff),
      .state_nxt  (state_in),
      .result     (step_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance && step_result.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_tdata;
         in_end_ff  <= req_tuser[0];
      end
      if (advance && step_result.emit) begin
         out_cp_ff     <= step_result.code_point;
         out_status_ff <= step_result.status;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_cp_ff};
   assign rsp_tuser  = out_status_ff;

   `UBSD_ASSERT(a_fail_cp_zero, rsp_tvalid && rsp_tuser != STATUS_OK |-> rsp_tdata[20:0] == '0, "error or end item carries a non-zero code point")
   `UBSD_ASSERT(a_cp_scalar, rsp_tvalid && rsp_tuser == STATUS_OK |-> rsp_tdata[20:0] <= CP_MAX && (rsp_tdata[20:0] < SURROGATE_LO || rsp_tdata[20:0] > SURROGATE_HI), "decoded code point is not a scalar value")
   `UBSD_ASSERT(a_status_code, rsp_tvalid |-> rsp_tuser <= STATUS_END, "undefined status on rsp")
   `UBSD_ASSERT(a_partial_narrow, state_ff.pending != PEND_IDLE |-> state_ff.partial[CP_W-1:CP_W-PAYLOAD_W] == '0, "partial value too wide for pending count")
   `UBSD_ASSERT_ALWAYS(a_reset_idle, $past(reset) |-> state_ff.pending == PEND_IDLE && !rsp_tvalid, "decoder not idle after reset")

endmodule

// ===== dv/utf8_decode_checker.sv =====
module utf8_decode_checker
   import ubsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_in
   input  logic [0:0]  req_tuser,   // [0] stream_end
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // [20:0] code_point, [23:21] zero
   input  logic [1:0]  rsp_tuser,   // [1:0] status
   output int          mismatches,
   output int          awaited,
   output int          chars_seen,
   output int          errors_seen,
   output int          ends_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [CP_W-1:0] code_point;
      status_type      status;
   } symbol_type;

   symbol_type        symbol_q[$];
   logic [PEND_W-1:0] cont_left = PEND_IDLE;
   logic [CP_W-1:0]   gathered  = '0;
   int                fail_count = 0;
   int                queued     = 0;
   int                n_chars    = 0;
   int                n_errors   = 0;
   int                n_ends     = 0;

   assign mismatches  = fail_count;
   assign awaited     = queued;
   assign chars_seen  = n_chars;
   assign errors_seen = n_errors;
   assign ends_seen   = n_ends;

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("%0t ns mismatch: %s, got %0h, expected %0h", $time, what, got, want);
      fail_count++;
   endtask

   task automatic expect_symbol(input logic [CP_W-1:0] cp, input status_type st);
      symbol_type s;
      s.code_point = cp;
      s.status     = st;
      symbol_q.push_back(s);
   endtask

   task automatic abandon_sequence();
      cont_left = PEND_IDLE;
      gathered  = '0;
      expect_symbol('0, STATUS_ERR);
   endtask

   // advance the decoder by one item and queue whatever it yields
   task automatic decode_byte(input logic [7:0] b, input logic fin);
      logic [CP_W-1:0] cp;
      cp = '0;
      if (fin) begin
         if (cont_left != PEND_IDLE) begin
            abandon_sequence();
         end else begin
            expect_symbol('0, STATUS_END);
         end
      end else if (cont_left == PEND_IDLE) begin
         if (b < ASCII_LIMIT) begin
            expect_symbol(CP_W'(b), STATUS_OK);
         end else if (b >= LEAD2_MIN && b < LEAD3_MIN) begin
            cont_left = PEND_ONE;
            gathered  = CP_W'(b & LEAD2_MASK);
         end else if (b >= LEAD3_MIN && b < LEAD4_MIN) begin
            cont_left = PEND_TWO;
            gathered  = CP_W'(b & LEAD3_MASK);
         end else if (b >= LEAD4_MIN && b < LEAD_LIMIT) begin
            cont_left = PEND_THREE;
            gathered  = CP_W'(b & LEAD4_MASK);
         end else begin
            abandon_sequence();
         end
      end else if ((b & CONT_MASK) != CONT_TAG) begin
         abandon_sequence();
      end else begin
         gathered  = {gathered[CP_W-1-PAYLOAD_W:0], b[PAYLOAD_W-1:0]};
         cont_left = cont_left - PEND_ONE;
         if (cont_left == PEND_IDLE) begin
            cp       = gathered;
            gathered = '0;
            if ((cp >= SURROGATE_LO && cp <= SURROGATE_HI) || cp > CP_MAX) begin
               abandon_sequence();
            end else begin
               expect_symbol(cp, STATUS_OK);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      symbol_type want;
      if (reset) begin
         symbol_q.delete();
         cont_left = PEND_IDLE;
         gathered  = '0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            case (rsp_tuser)
               STATUS_OK:  n_chars++;
               STATUS_ERR: n_errors++;
               STATUS_END: n_ends++;
               default:    ;
            endcase
            if (symbol_q.size() == 0) begin
               report("result with nothing awaited", 32'(rsp_tdata), '0);
            end else begin
               want = symbol_q.pop_front();
               if (rsp_tdata[CP_W-1:0] != want.code_point)
                  report("code_point", 32'(rsp_tdata[CP_W-1:0]), 32'(want.code_point));
               if (rsp_tdata[23:CP_W] != '0)
                  report("tdata padding", 32'(rsp_tdata[23:CP_W]), '0);
               if (rsp_tuser != want.status)
                  report("status", 32'(rsp_tuser), 32'(want.status));
            end
         end
         if (req_tvalid && req_tready)
            decode_byte(req_tdata, req_tuser[0]);
      end
      queued <= symbol_q.size();
   end

endmodule

// ===== dv/utf8_byte_stream_decoder_tb.sv =====
module utf8_byte_stream_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT  = 2000;
   localparam int PHASE_ITEMS = 306;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic [0:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   int send_gap_pct  = 0;
   int rsp_stall_pct = 0;
   int items_sent    = 0;
   int ends_sent     = 0;
   int quiet_cycles  = 0;
   int mismatches, awaited, chars_seen, errors_seen, ends_seen;

   // bit 8 marks end of stream; byte field is ignored then
   logic [8:0] opening_seq[$] = '{
      9'h000, 9'h07F,
      9'h0C2, 9'h080,
      9'h0E0, 9'h080, 9'h080,
      9'h0ED, 9'h0A0, 9'h080,
      9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,
      9'h0F4, 9'h090, 9'h080, 9'h080,
      9'h080, 9'h0FF,
      9'h0C2, 9'h041,
      9'h0E0, 9'h100,
      9'h1FF, 9'h100
   };

   always #5 clock = ~clock;

   utf8_byte_stream_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   utf8_decode_checker decode_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .mismatches  (mismatches),
      .awaited     (awaited),
      .chars_seen  (chars_seen),
      .errors_seen (errors_seen),
      .ends_seen   (ends_seen)
   );

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99, 0) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == IDLE_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [7:0] cont_byte();
      return {2'b10, 6'($urandom)};
   endfunction

   task automatic send_item(input logic [7:0] b, input logic fin);
      while ($urandom_range(99, 0) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      if (fin) ends_sent++;
   endtask

   // hold the sender until every awaited result has arrived
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (awaited != 0) @(posedge clock);
   endtask

   task automatic run_phase(input int gap, input int stall, input int n);
      int         first, kind, len, keep;
      logic [7:0] lead, breaker;
      send_gap_pct  = gap;
      rsp_stall_pct = stall;
      first = items_sent;
      while (items_sent - first < n) begin
         kind = $urandom_range(99, 0);
         len  = $urandom_range(3, 1);
         case (len)
            1:       lead = 8'($urandom_range(8'hDF, 8'hC2));
            2:       lead = 8'($urandom_range(8'hEF, 8'hE0));
            default: lead = 8'($urandom_range(8'hF4, 8'hF0));
         endcase
         if (kind < 28) begin
            send_item(8'($urandom_range(8'h7F, 0)), 1'b0);
         end else if (kind < 80) begin
            send_item(lead, 1'b0);
            repeat (len) send_item(cont_byte(), 1'b0);
         end else if (kind < 88) begin
            keep = $urandom_range(len - 1, 0);
            send_item(lead, 1'b0);
            repeat (keep) send_item(cont_byte(), 1'b0);
            breaker       = 8'($urandom);
            breaker[7:6] = ($urandom_range(2, 0) == 2) ? 2'b11 : 2'($urandom_range(1, 0));
            send_item(breaker, $urandom_range(1, 0) == 1);
         end else if (kind < 96) begin
            send_item(8'($urandom), 1'b0);
         end else begin
            send_item(8'($urandom), 1'b1);
         end
         if ($urandom_range(63, 0) == 0) drain();
      end
      drain();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      foreach (opening_seq[i]) send_item(opening_seq[i][7:0], opening_seq[i][8]);
      drain();
      run_phase(0, 0, PHASE_ITEMS);
      run_phase(63, 0, PHASE_ITEMS);
      run_phase(0, 63, PHASE_ITEMS);
      run_phase(16, 16, PHASE_ITEMS);
      repeat (8) @(posedge clock);
      $display("sent %0d items (%0d end markers) through idle, sender-gap, receiver-stall and mixed phases",
               items_sent, ends_sent);
      $display("checked %0d code points, %0d encoding errors, %0d end results",
               chars_seen, errors_seen, ends_seen);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
